// ----- src/odka_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odka_pkg
// Shared widths, constants and the oct packing function for the unique-oct
// key assigner.
// ----------------------------------------------------------------------------
package odka_pkg;

	// Table capacity; key 0 is reserved, so keys 1 .. MAX_ENTRIES-1 are stored.
	localparam int MAX_ENTRIES = 256;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int KEY_W       = 9;
	localparam int NUM_SYM     = 8;
	localparam int SYM_W       = 8;
	localparam int OCT_W       = NUM_SYM * SYM_W;
	localparam int SW_W        = 4;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;

	// Register index of symbol_width, and its value after reset.
	localparam logic [0:0]      REG_SYMBOL_WIDTH = 1'b0;
	localparam logic [SW_W-1:0] SW_RESET         = 4'd2;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [OCT_W-1:0] oct_t;
	typedef logic [KEY_W-1:0] key_t;

	// Clamp the configured width into 1 .. 8.
	function automatic logic [SW_W-1:0] eff_width(input logic [SW_W-1:0] sw);
		logic [SW_W-1:0] w;
		if (sw == '0) begin
			w = 4'd1;
		end else if (sw > 4'd8) begin
			w = 4'd8;
		end else begin
			w = sw;
		end
		return w;
	endfunction

	// Pack eight symbols into w-bit fields, symbol 0 in the lowest field.
	function automatic oct_t pack_short(input sym_t syms [NUM_SYM],
	                                    input logic [SW_W-1:0] w);
		oct_t       acc;
		sym_t       mask;
		logic [5:0] sh;
		acc  = '0;
		mask = SYM_W'((9'd1 << w) - 9'd1);
		for (int k = 0; k < NUM_SYM; k++) begin
			sh  = 6'(k * int'(w));
			acc = acc | (OCT_W'(syms[k] & mask) << sh);
		end
		return acc;
	endfunction

endpackage

// ----- src/odka_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odka_req_if / odka_rsp_if
// Valid/ready channels carrying one symbol group in and one key result out.
// ----------------------------------------------------------------------------
interface odka_req_if;
	logic           valid;
	logic           ready;
	logic           begin_table;
	odka_pkg::sym_t symbol_0;
	odka_pkg::sym_t symbol_1;
	odka_pkg::sym_t symbol_2;
	odka_pkg::sym_t symbol_3;
	odka_pkg::sym_t symbol_4;
	odka_pkg::sym_t symbol_5;
	odka_pkg::sym_t symbol_6;
	odka_pkg::sym_t symbol_7;

	modport source (output valid, begin_table, symbol_0, symbol_1, symbol_2, symbol_3,
	                symbol_4, symbol_5, symbol_6, symbol_7, input ready);
	modport sink (input valid, begin_table, symbol_0, symbol_1, symbol_2, symbol_3,
	              symbol_4, symbol_5, symbol_6, symbol_7, output ready);
endinterface

interface odka_rsp_if;
	logic           valid;
	logic           ready;
	odka_pkg::key_t doubled_key;
	logic           is_new;
	odka_pkg::oct_t expanded_oct;
	odka_pkg::key_t entry_count;
	logic           table_full;

	modport source (output valid, doubled_key, is_new, expanded_oct, entry_count,
	                table_full, input ready);
	modport sink (input valid, doubled_key, is_new, expanded_oct, entry_count,
	              table_full, output ready);
endinterface

// ----- src/oct_dedup_key_assign.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oct_dedup_key_assign
// Assigns keys to unique packed octs of encoder output symbols.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An accepted group is packed, then the
// stored octs are read from the table memory one entry per cycle, keys 1
// upward, and compared against the new oct. A hit ends the search at the
// first matching key; a miss is found once every stored key has been read.
// The input is ready again from the edge that loads the result. The result
// sits in an output register, so a finished result may wait for the sink
// while the block is already idle for the next group; a new result is
// loaded only once the previous one has been transferred, and the block
// holds its result state until then. No clearing pass is needed after
// reset: only keys below the next free key are ever read.
// ----------------------------------------------------------------------------
module oct_dedup_key_assign (
	input  logic                                 clk,
	input  logic                                 arst_n,
	odka_req_if.sink                             req,
	odka_rsp_if.source                           rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [odka_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [odka_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [odka_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RESULT
	} state_t;

	state_t                         state_q;
	logic [odka_pkg::SW_W-1:0]      symbol_width_q;
	odka_pkg::oct_t                 short_q;
	odka_pkg::oct_t                 expanded_q;
	odka_pkg::key_t                 next_key_q;
	odka_pkg::key_t                 addr_q;
	logic                           rd_valid_s1;
	logic [odka_pkg::ADDR_W-1:0]    rd_key_s1;
	odka_pkg::oct_t                 rd_data_s1;
	odka_pkg::key_t                 res_key_q;
	logic                           res_new_q;
	logic                           res_full_q;

	odka_pkg::oct_t                 oct_mem [odka_pkg::MAX_ENTRIES];

	odka_pkg::sym_t                 syms [odka_pkg::NUM_SYM];
	odka_pkg::oct_t                 short_d;
	logic                           in_xfer;
	logic                           issue;
	logic                           hit;
	logic                           miss;
	logic                           has_room;
	logic                           mem_we;
	logic                           out_free;
	logic                           cfg_wr;

	// Configuration register; the write completes in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == odka_pkg::REG_SYMBOL_WIDTH);
	assign prdata = (paddr[2] == odka_pkg::REG_SYMBOL_WIDTH)
	              ? odka_pkg::CFG_DATA_W'(symbol_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_width_q <= odka_pkg::SW_RESET;
		end else if (cfg_wr) begin
			symbol_width_q <= pwdata[odka_pkg::SW_W-1:0];
		end
	end

	// Pack the incoming group into the short oct.
	always_comb begin
		syms[0] = req.symbol_0;
		syms[1] = req.symbol_1;
		syms[2] = req.symbol_2;
		syms[3] = req.symbol_3;
		syms[4] = req.symbol_4;
		syms[5] = req.symbol_5;
		syms[6] = req.symbol_6;
		syms[7] = req.symbol_7;
		short_d = odka_pkg::pack_short(syms, odka_pkg::eff_width(symbol_width_q));
	end

	assign req.ready = (state_q == ST_IDLE);
	assign in_xfer   = req.valid && req.ready;

	// Search control: one read per cycle while keys remain below the next free key.
	assign issue    = (state_q == ST_SEARCH) && (addr_q < next_key_q);
	assign hit      = (state_q == ST_SEARCH) && rd_valid_s1 && (rd_data_s1 == short_q);
	assign miss     = (state_q == ST_SEARCH) && !hit && !issue && !rd_valid_s1;
	assign has_room = next_key_q < odka_pkg::KEY_W'(odka_pkg::MAX_ENTRIES);
	assign mem_we   = miss && has_room;
	assign out_free = !rsp.valid || rsp.ready;

	// Table memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			oct_mem[next_key_q[odka_pkg::ADDR_W-1:0]] <= short_q;
		end
		rd_data_s1 <= oct_mem[addr_q[odka_pkg::ADDR_W-1:0]];
	end

	// State machine, search state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			short_q          <= '0;
			expanded_q       <= '0;
			next_key_q       <= odka_pkg::KEY_W'(1);
			addr_q           <= odka_pkg::KEY_W'(1);
			rd_valid_s1      <= 1'b0;
			rd_key_s1        <= '0;
			res_key_q        <= '0;
			res_new_q        <= 1'b0;
			res_full_q       <= 1'b0;
			rsp.valid        <= 1'b0;
			rsp.doubled_key  <= '0;
			rsp.is_new       <= 1'b0;
			rsp.expanded_oct <= '0;
			rsp.entry_count  <= '0;
			rsp.table_full   <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			rd_key_s1   <= addr_q[odka_pkg::ADDR_W-1:0];
			// A new result replaces the old one; otherwise a transfer empties the register.
			if ((state_q == ST_RESULT) && out_free) begin
				rsp.valid <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						short_q    <= short_d;
						expanded_q <= {req.symbol_7, req.symbol_6, req.symbol_5, req.symbol_4,
						               req.symbol_3, req.symbol_2, req.symbol_1, req.symbol_0};
						if (req.begin_table) begin
							next_key_q <= odka_pkg::KEY_W'(1);
						end
						addr_q      <= odka_pkg::KEY_W'(1);
						state_q     <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						res_key_q  <= {rd_key_s1, 1'b0};
						res_new_q  <= 1'b0;
						res_full_q <= 1'b0;
						state_q    <= ST_RESULT;
					end else if (miss) begin
						if (has_room) begin
							res_key_q  <= {next_key_q[odka_pkg::ADDR_W-1:0], 1'b0};
							res_new_q  <= 1'b1;
							res_full_q <= 1'b0;
							next_key_q <= next_key_q + odka_pkg::KEY_W'(1);
						end else begin
							res_key_q  <= '0;
							res_new_q  <= 1'b0;
							res_full_q <= 1'b1;
						end
						state_q <= ST_RESULT;
					end else if (issue) begin
						addr_q <= addr_q + odka_pkg::KEY_W'(1);
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						rsp.doubled_key  <= res_key_q;
						rsp.is_new       <= res_new_q;
						rsp.expanded_oct <= res_new_q ? expanded_q : '0;
						rsp.entry_count  <= next_key_q;
						rsp.table_full   <= res_full_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The next free key always stays within 1 .. MAX_ENTRIES.
	a_next_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_key_q != '0) && (next_key_q <= odka_pkg::KEY_W'(odka_pkg::MAX_ENTRIES)))
		else $error("next free key out of range");

	// A new entry takes the key just below the reported entry count.
	a_new_key: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.is_new) |->
		(rsp.doubled_key == {rsp.entry_count[odka_pkg::ADDR_W-1:0] - 8'd1, 1'b0}))
		else $error("new entry key does not match entry count");

	// A full table answers key 0 and stores nothing.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.table_full) |->
		(rsp.doubled_key == '0) && !rsp.is_new && (rsp.expanded_oct == '0))
		else $error("full table result malformed");

	// The memory is never written while the block waits for a new group.
	a_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == ST_RESULT))
		else $error("table write outside a search");
`endif

endmodule
